[src/ntsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_pkg: shared definitions for the nearest target select and aim block
// Widths, register indexes, reset values and the multiplier request type.
// ----------------------------------------------------------------------------
package ntsa_pkg;

   // coordinate width of box fields and center offsets (Q10.4 pixels)
   localparam int COORD_BITS = 14;
   localparam int CLASS_BITS = 4;
   localparam int GAIN_BITS  = 16;
   localparam int BIAS_BITS  = 16;
   localparam int ANGLE_BITS = 16;

   // squared distance width
   localparam int DIST_BITS  = 2 * COORD_BITS + 2;

   // shared multiplier operand: holds a center (Q.5) or a gain as signed
   localparam int OPND_BITS  = (COORD_BITS + 3 > GAIN_BITS + 1) ?
                               COORD_BITS + 3 : GAIN_BITS + 1;
   localparam int PROD_BITS  = 2 * OPND_BITS;

   // bias Q.4 lifted to Q.13
   localparam int BIAS_SHIFT = 9;
   localparam int FRAC_SHIFT = 13;
   localparam int BIAS_TERM_BITS = BIAS_BITS + BIAS_SHIFT + 1;
   localparam int ACC_BITS   = ((PROD_BITS > BIAS_TERM_BITS) ?
                               PROD_BITS : BIAS_TERM_BITS) + 1;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (COORD_BITS > 16) ? COORD_BITS : 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_ENEMY_CLASS     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER_OFFSET_X = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER_OFFSET_Y = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_THETA_GAIN      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_PHI_GAIN        = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_THETA_BIAS      = 3'd5;

   localparam logic [CLASS_BITS-1:0] RST_ENEMY_CLASS   = 4'd0;
   localparam logic [COORD_BITS-1:0] RST_CENTER_OFFSET = COORD_BITS'(1664);
   localparam logic [GAIN_BITS-1:0]  RST_THETA_GAIN    = 16'd256;
   localparam logic [GAIN_BITS-1:0]  RST_PHI_GAIN      = 16'd2560;
   localparam logic [BIAS_BITS-1:0]  RST_THETA_BIAS    = 16'd25133;

   // request to the shared multiplier
   typedef struct packed {
      logic                        en;
      logic signed [OPND_BITS-1:0] a;
      logic signed [OPND_BITS-1:0] b;
   } mul_req_type;

endpackage

[src/ntsa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_req_if / ntsa_rsp_if: detection and aim channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ntsa_req_if import ntsa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  present;
   logic [COORD_BITS-1:0] box_x;
   logic [COORD_BITS-1:0] box_y;
   logic [COORD_BITS-1:0] box_w;
   logic [COORD_BITS-1:0] box_h;
   logic [CLASS_BITS-1:0] box_class;
   logic                  frame_end;

   modport source (output valid, present, box_x, box_y, box_w, box_h, box_class,
                   frame_end, input ready);
   modport sink   (input valid, present, box_x, box_y, box_w, box_h, box_class,
                   frame_end, output ready);
endinterface

interface ntsa_rsp_if import ntsa_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [ANGLE_BITS-1:0]        theta_mrad;
   logic signed [ANGLE_BITS-1:0] phi_mrad;

   modport source (output valid, theta_mrad, phi_mrad, input ready);
   modport sink   (input valid, theta_mrad, phi_mrad, output ready);
endinterface

[src/nearest_target_select_aim.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_select_aim: nearest enemy detection and gimbal angles
// Keeps the enemy-class detection of a frame nearest to the last target and,
// at frame end, turns its box center into elevation and azimuth commands.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  req_bus  in         valid/ready        present, box_x/y/w/h, box_class,
//                                         frame_end
//  rsp_bus  out        valid/ready        theta_mrad, phi_mrad
//  csr_*    in         write enable only  csr_index, csr_wdata
//
//  A detection of the enemy class runs dx*dx and dy*dy through the one
//  shared multiplier and compares the sum; any other item needs no distance
//  multiply. A frame end with a found target adds two more multiplies for
//  theta and phi. The result sits in an output register; the next result
//  stalls only while that register is still unread.
//  Reset is synchronous, active high, and restores registers and target.
// ----------------------------------------------------------------------------
module nearest_target_select_aim import ntsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   ntsa_req_if.sink                 req_bus,
   ntsa_rsp_if.source               rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DX   = 3'd1;
   localparam logic [2:0] ST_DY   = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_TH   = 3'd4;
   localparam logic [2:0] ST_PH   = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   // clamp a Q.13 sum to the unsigned theta range, flooring the fraction
   function automatic logic [ANGLE_BITS-1:0] sat_theta(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [ACC_BITS-1:0] whole;
      whole = acc >>> FRAC_SHIFT;
      if (whole < 0) begin
         sat_theta = '0;
      end else if (whole > signed'(ACC_BITS'(65535))) begin
         sat_theta = '1;
      end else begin
         sat_theta = whole[ANGLE_BITS-1:0];
      end
   endfunction

   // clamp a Q.13 sum to the signed phi range, flooring the fraction
   function automatic logic [ANGLE_BITS-1:0] sat_phi(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [ACC_BITS-1:0] whole;
      whole = acc >>> FRAC_SHIFT;
      if (whole < signed'(ACC_BITS'(-32768))) begin
         sat_phi = 16'h8000;
      end else if (whole > signed'(ACC_BITS'(32767))) begin
         sat_phi = 16'h7fff;
      end else begin
         sat_phi = whole[ANGLE_BITS-1:0];
      end
   endfunction

   // configuration registers
   logic [CLASS_BITS-1:0] enemy_class_ff;
   logic [COORD_BITS-1:0] center_offset_x_ff;
   logic [COORD_BITS-1:0] center_offset_y_ff;
   logic [GAIN_BITS-1:0]  theta_gain_ff;
   logic [GAIN_BITS-1:0]  phi_gain_ff;
   logic [BIAS_BITS-1:0]  theta_bias_ff;

   // control state
   logic [2:0]            state_ff, state_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic [DIST_BITS-1:0]  best_dist_ff, best_dist_in;
   logic                  best_found_ff, best_found_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [COORD_BITS-1:0] item_x_ff, item_x_in;
   logic [COORD_BITS-1:0] item_y_ff, item_y_in;
   logic [COORD_BITS-1:0] item_w_ff, item_w_in;
   logic [COORD_BITS-1:0] item_h_ff, item_h_in;
   logic                  item_end_ff, item_end_in;
   logic [COORD_BITS-1:0] best_x_ff, best_x_in;
   logic [COORD_BITS-1:0] best_y_ff, best_y_in;
   logic [COORD_BITS-1:0] best_w_ff, best_w_in;
   logic [COORD_BITS-1:0] best_h_ff, best_h_in;
   logic [DIST_BITS-1:0]  dx_sq_ff, dx_sq_in;
   logic [ANGLE_BITS-1:0] theta_ff, theta_in;
   logic [ANGLE_BITS-1:0] rsp_theta_ff, rsp_theta_in;
   logic [ANGLE_BITS-1:0] rsp_phi_ff, rsp_phi_in;

   // datapath
   mul_req_type                 mul_req;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [OPND_BITS-1:0] dx, dy, xc, yc;
   logic [DIST_BITS-1:0]        dist_sum;
   logic signed [ACC_BITS-1:0]  th_sum, ph_sum;
   logic                        req_xfer, match;

   ntsa_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign req_xfer           = req_bus.valid & req_bus.ready;
   assign match              = req_bus.present & (req_bus.box_class == enemy_class_ff);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.theta_mrad = rsp_theta_ff;
   assign rsp_bus.phi_mrad   = signed'(rsp_phi_ff);

   // offsets from the last target and centers of the kept box (Q.5)
   always_comb begin
      dx = signed'(OPND_BITS'(item_x_ff)) - signed'(OPND_BITS'(prev_x_ff));
      dy = signed'(OPND_BITS'(item_y_ff)) - signed'(OPND_BITS'(prev_y_ff));
      xc = signed'(OPND_BITS'({best_x_ff, 1'b0})) + signed'(OPND_BITS'(best_w_ff))
         - signed'(OPND_BITS'({center_offset_x_ff, 1'b0}));
      yc = signed'(OPND_BITS'({best_y_ff, 1'b0})) + signed'(OPND_BITS'(best_h_ff))
         - signed'(OPND_BITS'({center_offset_y_ff, 1'b0}));
      dist_sum = dx_sq_ff + DIST_BITS'(prod_ff);
      th_sum   = ACC_BITS'(prod_ff) + signed'(ACC_BITS'({theta_bias_ff, 9'b0}));
      ph_sum   = ACC_BITS'(prod_ff);
   end

   // sequencer and next-state values
   always_comb begin
      state_in      = state_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      best_dist_in  = best_dist_ff;
      best_found_in = best_found_ff;
      item_x_in     = item_x_ff;
      item_y_in     = item_y_ff;
      item_w_in     = item_w_ff;
      item_h_in     = item_h_ff;
      item_end_in   = item_end_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      best_w_in     = best_w_ff;
      best_h_in     = best_h_ff;
      dx_sq_in      = dx_sq_ff;
      theta_in      = theta_ff;
      rsp_theta_in  = rsp_theta_ff;
      rsp_phi_in    = rsp_phi_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_bus.ready;
      mul_req.en    = 1'b0;
      mul_req.a     = dx;
      mul_req.b     = dx;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               item_x_in   = req_bus.box_x;
               item_y_in   = req_bus.box_y;
               item_w_in   = req_bus.box_w;
               item_h_in   = req_bus.box_h;
               item_end_in = req_bus.frame_end;
               if (match) begin
                  state_in = ST_DX;
               end else if (req_bus.frame_end) begin
                  if (best_found_ff) begin
                     state_in = ST_TH;
                  end else begin
                     best_dist_in = '1;
                  end
               end
            end
         end
         ST_DX: begin
            // square the x offset
            mul_req.en = 1'b1;
            state_in   = ST_DY;
         end
         ST_DY: begin
            // park dx squared, square the y offset
            dx_sq_in   = DIST_BITS'(prod_ff);
            mul_req.en = 1'b1;
            mul_req.a  = dy;
            mul_req.b  = dy;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            // keep the first strictly nearer detection
            if (dist_sum < best_dist_ff) begin
               best_dist_in  = dist_sum;
               best_found_in = 1'b1;
               best_x_in     = item_x_ff;
               best_y_in     = item_y_ff;
               best_w_in     = item_w_ff;
               best_h_in     = item_h_ff;
            end
            state_in = item_end_ff ? ST_TH : ST_IDLE;
         end
         ST_TH: begin
            mul_req.en = 1'b1;
            mul_req.a  = yc;
            mul_req.b  = signed'(OPND_BITS'(theta_gain_ff));
            state_in   = ST_PH;
         end
         ST_PH: begin
            // finish theta, start phi
            theta_in   = sat_theta(th_sum);
            mul_req.en = 1'b1;
            mul_req.a  = xc;
            mul_req.b  = signed'(OPND_BITS'(phi_gain_ff));
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free, then close the frame
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_theta_in  = theta_ff;
               rsp_phi_in    = sat_phi(ph_sum);
               prev_x_in     = best_x_ff;
               prev_y_in     = best_y_ff;
               best_dist_in  = '1;
               best_found_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         best_dist_ff  <= '1;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         best_dist_ff  <= best_dist_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_x_ff    <= item_x_in;
      item_y_ff    <= item_y_in;
      item_w_ff    <= item_w_in;
      item_h_ff    <= item_h_in;
      item_end_ff  <= item_end_in;
      best_x_ff    <= best_x_in;
      best_y_ff    <= best_y_in;
      best_w_ff    <= best_w_in;
      best_h_ff    <= best_h_in;
      dx_sq_ff     <= dx_sq_in;
      theta_ff     <= theta_in;
      rsp_theta_ff <= rsp_theta_in;
      rsp_phi_ff   <= rsp_phi_in;
   end

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         enemy_class_ff     <= RST_ENEMY_CLASS;
         center_offset_x_ff <= RST_CENTER_OFFSET;
         center_offset_y_ff <= RST_CENTER_OFFSET;
         theta_gain_ff      <= RST_THETA_GAIN;
         phi_gain_ff        <= RST_PHI_GAIN;
         theta_bias_ff      <= RST_THETA_BIAS;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ENEMY_CLASS:     enemy_class_ff     <= csr_wdata[CLASS_BITS-1:0];
            REG_CENTER_OFFSET_X: center_offset_x_ff <= csr_wdata[COORD_BITS-1:0];
            REG_CENTER_OFFSET_Y: center_offset_y_ff <= csr_wdata[COORD_BITS-1:0];
            REG_THETA_GAIN:      theta_gain_ff      <= csr_wdata[GAIN_BITS-1:0];
            REG_PHI_GAIN:        phi_gain_ff        <= csr_wdata[GAIN_BITS-1:0];
            REG_THETA_BIAS:      theta_bias_ff      <= csr_wdata[BIAS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

[src/ntsa_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_mul: shared signed multiplier
// One signed multiply per cycle with a registered product; the product holds
// while no request is issued.
// ----------------------------------------------------------------------------
module ntsa_mul import ntsa_pkg::*; (
   input  logic                        clock,
   input  mul_req_type                 mul_req,
   output logic signed [PROD_BITS-1:0] prod_ff
);

   logic signed [PROD_BITS-1:0] prod_in;

   // form the full-width product
   always_comb begin
      prod_in = PROD_BITS'(mul_req.a) * PROD_BITS'(mul_req.b);
   end

   // capture on request, hold otherwise
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

[sim/ntsa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntsa_checker: aim prediction and comparison for nearest_target_select_aim
// Watches the register port and both channels. Each detection transfer is
// scored against the last target. A frame end with a found target predicts
// one aim result. Aim transfers are compared in order with the predictions.
// ----------------------------------------------------------------------------
module ntsa_checker import ntsa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   ntsa_req_if                      req_bus,
   ntsa_rsp_if                      rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int unsigned              pending,
   output int                       failures
);

   typedef struct packed {
      logic [ANGLE_BITS-1:0]        theta;
      logic signed [ANGLE_BITS-1:0] phi;
   } aim_type;

   // register copies
   logic [CLASS_BITS-1:0] aim_class;
   logic [COORD_BITS-1:0] off_x;
   logic [COORD_BITS-1:0] off_y;
   logic [GAIN_BITS-1:0]  gain_theta;
   logic [GAIN_BITS-1:0]  gain_phi;
   logic [BIAS_BITS-1:0]  bias_theta;

   // tracking state
   logic [COORD_BITS-1:0] last_x;
   logic [COORD_BITS-1:0] last_y;
   logic [DIST_BITS-1:0]  near_range;
   logic                  near_found;
   logic [COORD_BITS-1:0] near_x;
   logic [COORD_BITS-1:0] near_y;
   logic [COORD_BITS-1:0] near_w;
   logic [COORD_BITS-1:0] near_h;

   aim_type aim_queue[$];
   int      fail_count = 0;

   always @(posedge clock) begin
      longint               dx;
      longint               dy;
      longint               xc;
      longint               yc;
      longint               th;
      longint               ph;
      logic [DIST_BITS-1:0] range_sq;
      aim_type              want;

      if (reset) begin
         aim_class  = RST_ENEMY_CLASS;
         off_x      = RST_CENTER_OFFSET;
         off_y      = RST_CENTER_OFFSET;
         gain_theta = RST_THETA_GAIN;
         gain_phi   = RST_PHI_GAIN;
         bias_theta = RST_THETA_BIAS;
         last_x     = '0;
         last_y     = '0;
         near_range = '1;
         near_found = 1'b0;
         aim_queue.delete();
      end else begin
         // apply register writes; unknown indexes drop
         if (csr_wr_en) begin
            case (csr_index)
               REG_ENEMY_CLASS:     aim_class  = csr_wdata[CLASS_BITS-1:0];
               REG_CENTER_OFFSET_X: off_x      = csr_wdata[COORD_BITS-1:0];
               REG_CENTER_OFFSET_Y: off_y      = csr_wdata[COORD_BITS-1:0];
               REG_THETA_GAIN:      gain_theta = csr_wdata[GAIN_BITS-1:0];
               REG_PHI_GAIN:        gain_phi   = csr_wdata[GAIN_BITS-1:0];
               REG_THETA_BIAS:      bias_theta = csr_wdata[BIAS_BITS-1:0];
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            // keep the enemy detection nearest the last target; ties keep the first
            if (req_bus.present && req_bus.box_class == aim_class) begin
               dx = longint'(req_bus.box_x) - longint'(last_x);
               dy = longint'(req_bus.box_y) - longint'(last_y);
               range_sq = DIST_BITS'(dx * dx + dy * dy);
               if (range_sq < near_range) begin
                  near_range = range_sq;
                  near_found = 1'b1;
                  near_x     = req_bus.box_x;
                  near_y     = req_bus.box_y;
                  near_w     = req_bus.box_w;
                  near_h     = req_bus.box_h;
               end
            end

            // close the frame: aim at the chosen box and move the target
            if (req_bus.frame_end) begin
               if (near_found) begin
                  // centers in half pixels of Q10.4, products in Q.13
                  xc = 2 * longint'(near_x) + longint'(near_w) - 2 * longint'(off_x);
                  yc = 2 * longint'(near_y) + longint'(near_h) - 2 * longint'(off_y);
                  th = yc * longint'(gain_theta) + (longint'(bias_theta) <<< BIAS_SHIFT);
                  ph = xc * longint'(gain_phi);
                  th = th >>> FRAC_SHIFT;
                  ph = ph >>> FRAC_SHIFT;
                  if (th < 0) th = 0;
                  if (th > 65535) th = 65535;
                  if (ph < -32768) ph = -32768;
                  if (ph > 32767) ph = 32767;
                  want.theta = th[ANGLE_BITS-1:0];
                  want.phi   = ph[ANGLE_BITS-1:0];
                  aim_queue.push_back(want);
                  last_x = near_x;
                  last_y = near_y;
               end
               near_range = '1;
               near_found = 1'b0;
            end
         end

         // compare each aim transfer with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (aim_queue.size() == 0) begin
               $error("aim transfer with none predicted: theta_mrad %0d phi_mrad %0d",
                      rsp_bus.theta_mrad, rsp_bus.phi_mrad);
               fail_count++;
            end else begin
               want = aim_queue.pop_front();
               if (rsp_bus.theta_mrad !== want.theta) begin
                  $error("theta_mrad: expected %0d, got %0d", want.theta, rsp_bus.theta_mrad);
                  fail_count++;
               end
               if (rsp_bus.phi_mrad !== want.phi) begin
                  $error("phi_mrad: expected %0d, got %0d", want.phi, rsp_bus.phi_mrad);
                  fail_count++;
               end
            end
         end
      end

      pending  <= aim_queue.size();
      failures <= fail_count;
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for nearest_target_select_aim
// Drives directed frames, then random frames under several register settings
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import ntsa_pkg::*;

   localparam int IDLE_PCT      = 16;
   localparam int DRAIN_CYCLES  = 16;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int RANDOM_PHASES = 6;
   localparam int STEADY_PHASE  = 3;

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
   localparam int REG_FIRST_UNUSED = int'(REG_THETA_BIAS) + 1;
   localparam int REG_LAST_UNUSED  = (1 << CSR_IDX_BITS) - 1;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int unsigned           pending;
   int                    failures;
   bit                    steady;
   logic [CLASS_BITS-1:0] enemy_sel;
   int                    phase_items;

   ntsa_req_if req_bus ();
   ntsa_rsp_if rsp_bus ();

   nearest_target_select_aim u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ntsa_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .failures  (failures)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("nearest_target_select_aim verification failed");
      $finish;
   end

   // aim receiver: stall at random outside the steady stretch
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // hold a register write for one edge; the caller drops the enable
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_BITS-1:0] cls,
                                 input logic [CSR_DATA_BITS-1:0] ox,
                                 input logic [CSR_DATA_BITS-1:0] oy,
                                 input logic [CSR_DATA_BITS-1:0] tg,
                                 input logic [CSR_DATA_BITS-1:0] pg,
                                 input logic [CSR_DATA_BITS-1:0] tb);
      write_reg(CSR_IDX_BITS'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                CSR_DATA_BITS'($urandom));
      write_reg(REG_ENEMY_CLASS, cls);
      write_reg(REG_CENTER_OFFSET_X, ox);
      write_reg(REG_CENTER_OFFSET_Y, oy);
      write_reg(REG_THETA_GAIN, tg);
      write_reg(REG_PHI_GAIN, pg);
      write_reg(REG_THETA_BIAS, tb);
      csr_wr_en <= 1'b0;
      enemy_sel = cls[CLASS_BITS-1:0];
   endtask

   // one detection transfer, after random idle cycles
   task automatic send_item(input logic                  present,
                            input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y,
                            input logic [COORD_BITS-1:0] w,
                            input logic [COORD_BITS-1:0] h,
                            input logic [CLASS_BITS-1:0] cls,
                            input logic                  fend);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.present   <= present;
      req_bus.box_x     <= x;
      req_bus.box_y     <= y;
      req_bus.box_w     <= w;
      req_bus.box_h     <= h;
      req_bus.box_class <= cls;
      req_bus.frame_end <= fend;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (present || fend) phase_items++;
   endtask

   // stop sending, wait out every predicted result and the trailing latency
   task automatic drain();
      int waited;
      req_bus.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return COORD_MAX;
      return COORD_BITS'($urandom);
   endfunction

   // random frame: mostly enemy detections, some other classes, empty markers
   // and repeated positions for ties
   task automatic send_frame();
      int                    count;
      int                    roll;
      logic                  present;
      logic [CLASS_BITS-1:0] cls;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] tie_x;
      logic [COORD_BITS-1:0] tie_y;
      bit                    have_tie;
      count    = $urandom_range(1, 6);
      have_tie = 1'b0;
      for (int i = 0; i < count; i++) begin
         roll    = $urandom_range(99);
         present = (roll >= 8);
         cls     = (roll < 60) ? enemy_sel : CLASS_BITS'($urandom);
         if (have_tie && $urandom_range(9) < 2) begin
            x = tie_x;
            y = tie_y;
         end else begin
            x = pick_coord();
            y = pick_coord();
         end
         tie_x    = x;
         tie_y    = y;
         have_tie = 1'b1;
         send_item(present, x, y, pick_coord(), pick_coord(), cls, i == count - 1);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.present   <= 1'b0;
      req_bus.box_x     <= '0;
      req_bus.box_y     <= '0;
      req_bus.box_w     <= '0;
      req_bus.box_h     <= '0;
      req_bus.box_class <= '0;
      req_bus.frame_end <= 1'b0;
      steady      = 1'b0;
      enemy_sel   = RST_ENEMY_CLASS;
      phase_items = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames at reset settings
      send_item(1'b0, '0, '0, '0, '0, RST_ENEMY_CLASS, 1'b1);           // empty frame
      send_item(1'b1, '0, '0, '0, '0, RST_ENEMY_CLASS, 1'b1);           // zero box
      send_item(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1, 1'b0);
      send_item(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                RST_ENEMY_CLASS, 1'b0);
      send_item(1'b1, 14'd100, 14'd200, 14'd50, 14'd60, RST_ENEMY_CLASS, 1'b0);
      send_item(1'b0, '0, '0, '0, '0, RST_ENEMY_CLASS, 1'b1);           // marker closes
      // three detections at equal distance: the first one wins
      send_item(1'b1, 14'd110, 14'd200, 14'd10, 14'd20, RST_ENEMY_CLASS, 1'b0);
      send_item(1'b1, 14'd90, 14'd200, 14'd30, 14'd40, RST_ENEMY_CLASS, 1'b0);
      send_item(1'b1, 14'd100, 14'd190, 14'd5, 14'd5, RST_ENEMY_CLASS, 1'b1);
      // no matching class: no result, target kept
      send_item(1'b1, 14'd110, 14'd200, '0, '0, CLASS_BITS'(1), 1'b1);
      // absent detection with matching fields is ignored
      send_item(1'b0, 14'd110, 14'd200, 14'd7, 14'd7, RST_ENEMY_CLASS, 1'b0);
      send_item(1'b1, 14'd5000, 14'd6000, COORD_MAX, '0, RST_ENEMY_CLASS, 1'b1);
      send_item(1'b1, 14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, RST_ENEMY_CLASS, 1'b1);
      send_item(1'b1, 14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA, RST_ENEMY_CLASS, 1'b1);
      drain();

      // saturate both angles low, then high
      apply_settings('1, '1, '1, '1, '1, '1);
      send_item(1'b1, '0, '0, '0, '0, '1, 1'b1);
      send_item(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1, 1'b1);
      drain();
      apply_settings('0, '1, '1, '0, '0, '0);
      send_item(1'b1, '0, '0, '0, '0, '0, 1'b1);
      drain();

      // random frames under several settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: apply_settings(CSR_DATA_BITS'(RST_ENEMY_CLASS),
                              CSR_DATA_BITS'(RST_CENTER_OFFSET),
                              CSR_DATA_BITS'(RST_CENTER_OFFSET),
                              CSR_DATA_BITS'(RST_THETA_GAIN),
                              CSR_DATA_BITS'(RST_PHI_GAIN),
                              CSR_DATA_BITS'(RST_THETA_BIAS));
            1: apply_settings('0, '0, '0, '0, '0, '0);
            2: apply_settings('1, '1, '1, '1, '1, '1);
            default: apply_settings(
                  ($urandom_range(3) < 2) ? CSR_DATA_BITS'($urandom_range(1))
                                          : CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom));
         endcase
         steady      = (phase == STEADY_PHASE);
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / RANDOM_PHASES) begin
            send_frame();
            // now and then hold off until every result is back
            if ($urandom_range(99) < 3) drain();
         end
         drain();
      end
      steady = 1'b0;

      if (failures == 0 && pending == 0) begin
         $display("nearest_target_select_aim verification clean");
      end else begin
         $display("nearest_target_select_aim verification failed");
      end
      $finish;
   end

endmodule
